// File: rtl/ansi_halfblock_cell_encoder_top_defines.svh
// assertion macros shared by the encoder rtl
// no dependencies; included by the modules that check their own logic
`ifndef ANSI_HALFBLOCK_CELL_ENCODER_TOP_DEFINES_SVH
`define ANSI_HALFBLOCK_CELL_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define AHCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ahce assertion failed");

// antecedent implies consequent in the next cycle
`define AHCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ahce assertion failed");

`else

`define AHCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AHCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/ahce_pkg.sv
// types, constants and byte tables of the half-block cell encoder
// no dependencies; used by every module of the block
package ahce_pkg;

    localparam int NUM_COMP = 6;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_THR  = 8'h33;
    localparam logic [7:0] CH_FOUR = 8'h34;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] HB_B0   = 8'hE2;
    localparam logic [7:0] HB_B1   = 8'h96;
    localparam logic [7:0] HB_B2   = 8'h80;

    localparam logic [2:0] FG_LAST  = 3'd6;
    localparam logic [2:0] BG_LAST  = 3'd5;
    localparam logic [2:0] HB_LAST  = 3'd2;
    localparam logic [2:0] RST_LAST = 3'd4;
    localparam logic [1:0] DIG_LAST = 2'd2;

    localparam logic [2:0] COMP_TOP_B = 3'd2;
    localparam logic [2:0] COMP_BOT_R = 3'd3;
    localparam logic [2:0] COMP_BOT_B = 3'd5;

    // decimal form of one 8-bit component: hundreds, tens, ones and the
    // index of the first digit printed (0 hundreds, 1 tens, 2 ones)
    typedef struct packed {
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
        logic [1:0] first;
    } t_dec;

    typedef struct packed {
        logic                     show_colour;
        logic                     row_end;
        t_dec [NUM_COMP-1:0]      comp;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_START,
        ST_FG,
        ST_DIG,
        ST_SEMI,
        ST_BG,
        ST_M,
        ST_HB,
        ST_RST
    } t_state;

    function automatic t_dec dec_split(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        t_dec        d;
        if (v >= 8'd200) begin
            h = 2'd2;
        end else if (v >= 8'd100) begin
            h = 2'd1;
        end else begin
            h = 2'd0;
        end
        rem  = 7'(v - ({6'd0, h} * 8'd100));
        // rem * 205 / 2048 is exact division by ten below 100
        prod = {8'd0, rem} * 15'd205;
        t    = prod[14:11];
        d.d2 = {2'd0, h};
        d.d1 = t;
        d.d0 = 4'(rem - ({3'd0, t} * 7'd10));
        if (v >= 8'd100) begin
            d.first = 2'd0;
        end else if (v >= 8'd10) begin
            d.first = 2'd1;
        end else begin
            d.first = 2'd2;
        end
        return d;
    endfunction

    function automatic logic [7:0] fg_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = CH_ESC;
            3'd1: b = CH_LBR;
            3'd2: b = CH_THR;
            3'd3: b = CH_EIGHT;
            3'd4: b = CH_SEMI;
            3'd5: b = CH_TWO;
            3'd6: b = CH_SEMI;
            default: b = CH_SEMI;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] bg_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = CH_SEMI;
            3'd1: b = CH_FOUR;
            3'd2: b = CH_EIGHT;
            3'd3: b = CH_SEMI;
            3'd4: b = CH_TWO;
            3'd5: b = CH_SEMI;
            default: b = CH_SEMI;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] hb_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = HB_B0;
            3'd1: b = HB_B1;
            3'd2: b = HB_B2;
            default: b = HB_B2;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] rst_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = CH_ESC;
            3'd1: b = CH_LBR;
            3'd2: b = CH_ZERO;
            3'd3: b = CH_M;
            3'd4: b = CH_LF;
            default: b = CH_LF;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] dig_sel(input t_dec d, input logic [1:0] idx);
        logic [3:0] r;
        case (idx)
            2'd0: r = d.d2;
            2'd1: r = d.d1;
            2'd2: r = d.d0;
            default: r = d.d0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ahce_front.sv
// front end: accepts cells, compares against the last pair sent in the row
// and builds the command for the byte sequencer; uses ahce_pkg
module ahce_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [23:0]       i_top_colour,
    input  logic [23:0]       i_bottom_colour,
    input  logic              i_bottom_present,
    input  logic              i_row_end,
    input  logic              i_q_full,
    output logic              o_push,
    output ahce_pkg::t_cmd    o_cmd
);

    logic [23:0] r_prev_top;
    logic [23:0] r_prev_bottom;
    logic        r_colour_sent;
    logic [23:0] n_prev_top;
    logic [23:0] n_prev_bottom;
    logic        n_colour_sent;

    logic [23:0] c_bottom;
    logic        c_change;

    assign o_stall  = i_q_full;
    assign o_push   = i_valid && !i_q_full;
    assign c_bottom = i_bottom_present ? i_bottom_colour : 24'd0;
    assign c_change = !r_colour_sent || (i_top_colour != r_prev_top)
                      || (c_bottom != r_prev_bottom);

    always_comb begin
        o_cmd.show_colour = c_change;
        o_cmd.row_end     = i_row_end;
        o_cmd.comp[0]     = ahce_pkg::dec_split(i_top_colour[23:16]);
        o_cmd.comp[1]     = ahce_pkg::dec_split(i_top_colour[15:8]);
        o_cmd.comp[2]     = ahce_pkg::dec_split(i_top_colour[7:0]);
        o_cmd.comp[3]     = ahce_pkg::dec_split(c_bottom[23:16]);
        o_cmd.comp[4]     = ahce_pkg::dec_split(c_bottom[15:8]);
        o_cmd.comp[5]     = ahce_pkg::dec_split(c_bottom[7:0]);
    end

    always_comb begin
        n_prev_top    = r_prev_top;
        n_prev_bottom = r_prev_bottom;
        n_colour_sent = r_colour_sent;
        if (o_push) begin
            if (i_row_end) begin
                n_prev_top    = 24'd0;
                n_prev_bottom = 24'd0;
                n_colour_sent = 1'b0;
            end else if (c_change) begin
                n_prev_top    = i_top_colour;
                n_prev_bottom = c_bottom;
                n_colour_sent = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_top    <= 24'd0;
            r_prev_bottom <= 24'd0;
            r_colour_sent <= 1'b0;
        end else begin
            r_prev_top    <= n_prev_top;
            r_prev_bottom <= n_prev_bottom;
            r_colour_sent <= n_colour_sent;
        end
    end

endmodule

// File: rtl/ahce_fifo.sv
// two-entry command queue between the front end and the byte sequencer
// uses ahce_pkg for the command type and the assertion macros header
`include "ansi_halfblock_cell_encoder_top_defines.svh"

module ahce_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ahce_pkg::t_cmd    i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_head_valid,
    output ahce_pkg::t_cmd    o_head
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    ahce_pkg::t_cmd   r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;

    assign o_full       = (r_count == (PW+1)'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `AHCE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `AHCE_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_head_valid)
    `AHCE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= (PW+1)'(DEPTH))

endmodule

// File: rtl/ahce_back.sv
// byte sequencer: walks the queue head command, emitting one byte per cycle
// unless stalled, into an output register; uses ahce_pkg and macros header
`include "ansi_halfblock_cell_encoder_top_defines.svh"

module ahce_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  ahce_pkg::t_cmd    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last_byte
);

    ahce_pkg::t_state r_state;
    ahce_pkg::t_state n_state;
    logic [2:0]       r_idx;
    logic [2:0]       n_idx;
    logic [2:0]       r_comp;
    logic [2:0]       n_comp;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             c_advance;
    logic             c_emit;
    logic [7:0]       c_byte;
    logic             c_last;
    ahce_pkg::t_dec   c_dec;
    ahce_pkg::t_dec   c_dec_next;
    logic [2:0]       c_comp_inc;

    assign c_advance  = !r_out_valid || !i_stall;
    assign c_emit     = c_advance && i_head_valid;
    assign o_pop      = c_emit && c_last;
    assign c_comp_inc = r_comp + 3'd1;
    assign c_dec      = i_head.comp[r_comp];
    assign c_dec_next = i_head.comp[c_comp_inc];

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_comp  = r_comp;
        c_byte  = ahce_pkg::HB_B0;
        c_last  = 1'b0;
        case (r_state)
            ahce_pkg::ST_START: begin
                n_idx = 3'd1;
                if (i_head.show_colour) begin
                    c_byte  = ahce_pkg::fg_byte(3'd0);
                    n_state = ahce_pkg::ST_FG;
                end else begin
                    c_byte  = ahce_pkg::hb_byte(3'd0);
                    n_state = ahce_pkg::ST_HB;
                end
            end
            ahce_pkg::ST_FG: begin
                c_byte = ahce_pkg::fg_byte(r_idx);
                if (r_idx == ahce_pkg::FG_LAST) begin
                    n_state = ahce_pkg::ST_DIG;
                    n_comp  = 3'd0;
                    n_idx   = {1'b0, i_head.comp[0].first};
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ahce_pkg::ST_DIG: begin
                c_byte = ahce_pkg::CH_ZERO
                         + {4'd0, ahce_pkg::dig_sel(c_dec, r_idx[1:0])};
                if (r_idx[1:0] == ahce_pkg::DIG_LAST) begin
                    n_idx = 3'd0;
                    if (r_comp == ahce_pkg::COMP_TOP_B) begin
                        n_state = ahce_pkg::ST_BG;
                    end else if (r_comp == ahce_pkg::COMP_BOT_B) begin
                        n_state = ahce_pkg::ST_M;
                    end else begin
                        n_state = ahce_pkg::ST_SEMI;
                    end
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ahce_pkg::ST_SEMI: begin
                c_byte  = ahce_pkg::CH_SEMI;
                n_state = ahce_pkg::ST_DIG;
                n_comp  = c_comp_inc;
                n_idx   = {1'b0, c_dec_next.first};
            end
            ahce_pkg::ST_BG: begin
                c_byte = ahce_pkg::bg_byte(r_idx);
                if (r_idx == ahce_pkg::BG_LAST) begin
                    n_state = ahce_pkg::ST_DIG;
                    n_comp  = ahce_pkg::COMP_BOT_R;
                    n_idx   = {1'b0, i_head.comp[3].first};
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ahce_pkg::ST_M: begin
                c_byte  = ahce_pkg::CH_M;
                n_state = ahce_pkg::ST_HB;
                n_idx   = 3'd0;
            end
            ahce_pkg::ST_HB: begin
                c_byte = ahce_pkg::hb_byte(r_idx);
                if (r_idx == ahce_pkg::HB_LAST) begin
                    n_idx = 3'd0;
                    if (i_head.row_end) begin
                        n_state = ahce_pkg::ST_RST;
                    end else begin
                        c_last  = 1'b1;
                        n_state = ahce_pkg::ST_START;
                    end
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ahce_pkg::ST_RST: begin
                c_byte = ahce_pkg::rst_byte(r_idx);
                if (r_idx == ahce_pkg::RST_LAST) begin
                    c_last  = 1'b1;
                    n_idx   = 3'd0;
                    n_state = ahce_pkg::ST_START;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            default: begin
                n_state = ahce_pkg::ST_START;
                n_idx   = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ahce_pkg::ST_START;
            r_idx   <= 3'd0;
            r_comp  <= 3'd0;
        end else if (c_emit) begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_comp  <= n_comp;
        end
    end

    // output register: refills in the same cycle the receiver takes a byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_advance) begin
            r_out_valid <= c_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_out_byte <= c_byte;
            r_out_last <= c_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

    `AHCE_ASSERT_IMP(a_mid_cell_has_head, i_clk, i_rst_n,
        r_state != ahce_pkg::ST_START, i_head_valid)
    `AHCE_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n,
        c_emit && c_last, r_state == ahce_pkg::ST_START && o_valid && o_last_byte)
    `AHCE_ASSERT_IMP(a_digit_index, i_clk, i_rst_n,
        r_state == ahce_pkg::ST_DIG, r_idx <= 3'd2 && r_comp <= ahce_pkg::COMP_BOT_B)

endmodule

// File: rtl/ansi_halfblock_cell_encoder_top.sv
// Half-block cell encoder: turns terminal cells into a true-color text byte stream.
// Input channel: i_valid / o_stall with one cell (top colour, bottom colour,
// bottom present, row end) per transaction. Output channel: o_valid / i_stall
// with one byte and a last-byte flag per transaction; the flag marks the final
// byte of a cell.
// A cell yields 3 bytes (half block only) up to 44 bytes (color sequence,
// half block and row reset). The byte sequencer emits one byte per cycle
// while i_stall is low; that single output port sets the throughput. When
// the queue is empty the first byte of a cell passes through the queue entry
// and then the output register on its way to the output.
// The front end compares and converts a cell in the cycle it is accepted and
// queues it; a two-entry queue lets new cells be taken while earlier ones are
// still being sent, and o_stall rises only when that queue is full.
// When i_stall is high with o_valid set, the byte holds and the sequencer waits.
// Reset (synchronous, active low) empties the queue and output register and
// forgets the last color pair, so the next cell always sends its colors.
// Depends on ahce_pkg, ahce_front, ahce_fifo and ahce_back.
module ansi_halfblock_cell_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_top_colour,
    input  logic [23:0] i_bottom_colour,
    input  logic        i_bottom_present,
    input  logic        i_row_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    ahce_pkg::t_cmd w_push_cmd;
    ahce_pkg::t_cmd w_head;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_head_valid;

    ahce_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_top_colour     (i_top_colour),
        .i_bottom_colour  (i_bottom_colour),
        .i_bottom_present (i_bottom_present),
        .i_row_end        (i_row_end),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_cmd            (w_push_cmd)
    );

    ahce_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_push_cmd),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    ahce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule
